@@ src/indexed_insert_delete_list_unit_macros.svh @@
// ============================================================================
// Assertion macros for the indexed insert/delete list unit
// Shared concurrent assertion forms used by the list unit RTL.
// ============================================================================
`ifndef INDEXED_INSERT_DELETE_LIST_UNIT_MACROS_SVH
`define INDEXED_INSERT_DELETE_LIST_UNIT_MACROS_SVH

// Same-cycle implication.
`define IIDL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IIDL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Invariant that holds at every clock edge out of reset.
`define IIDL_ASSERT_ALW(label, clk, rst_n, expr, msg) \
	`IIDL_ASSERT_IMP(label, clk, rst_n, 1'b1, expr, msg)

`endif

@@ src/iidl_pkg.sv @@
// ============================================================================
// iidl_pkg
// Types and constants shared by the indexed insert/delete list unit.
// ============================================================================
package iidl_pkg;

	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned LIMIT_W  = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
	localparam logic [OP_W-1:0] OP_READ   = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic [POS_W-1:0]          position;
		logic signed [VALUE_W-1:0] new_value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0]        entry_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SHIFT
	} state_t;

endpackage

@@ src/iidl_mem.sv @@
// ============================================================================
// iidl_mem
// Entry storage: one write port and one read port with registered read data.
// ============================================================================
module iidl_mem #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/iidl_ctrl.sv @@
// ============================================================================
// iidl_ctrl
// Request sequencer: checks each request, moves entries through the memory
// one per cycle for insert and delete, and registers the result.
// ============================================================================
`include "indexed_insert_delete_list_unit_macros.svh"

module iidl_ctrl #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  iidl_pkg::req_t                request,
	input  logic [iidl_pkg::LIMIT_W-1:0]  list_limit,
	output logic                          busy,
	output logic                          done,
	output iidl_pkg::rsp_t                result,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [DATA_WIDTH-1:0]         mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [DATA_WIDTH-1:0]         mem_rdata
);

	import iidl_pkg::*;

	localparam int unsigned CW    = $clog2(DEPTH + 1);
	localparam int unsigned CMPW  = (CW > POS_W) ? CW : POS_W;
	localparam int unsigned EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

	state_t                state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic [AW-1:0]         rd_ptr_q, rd_ptr_d;
	logic [CW-1:0]         moves_q, moves_d;
	logic                  pend_q, pend_d;
	logic [AW-1:0]         pend_addr_q, pend_addr_d;
	logic                  ins_q, ins_d;
	logic [AW-1:0]         pos_q, pos_d;
	logic [DATA_WIDTH-1:0] val_q, val_d;
	logic                  done_q, done_d;
	rsp_t                  rsp_q, rsp_d;

	logic [CMPW-1:0]         count_ext;
	logic [CMPW-1:0]         pos_ext;
	logic [CMPW-1:0]         limit_ext;
	logic [CMPW-1:0]         eff_limit;
	logic                    full;
	logic [DATA_WIDTH-1:0]   in_val;
	logic signed [EXT_W-1:0] rd_ext;

	assign count_ext = CMPW'(count_q);
	assign pos_ext   = CMPW'(request.position);
	assign limit_ext = CMPW'(list_limit);
	assign eff_limit = (limit_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : limit_ext;
	assign full      = count_ext >= eff_limit;
	assign in_val    = DATA_WIDTH'($unsigned(request.new_value));
	assign rd_ext    = EXT_W'($signed(mem_rdata));

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = rsp_q;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		rd_ptr_d    = rd_ptr_q;
		moves_d     = moves_q;
		pend_d      = 1'b0;
		pend_addr_d = pend_addr_q;
		ins_d       = ins_q;
		pos_d       = pos_q;
		val_d       = val_q;
		done_d      = 1'b0;
		rsp_d       = rsp_q;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = '0;
		mem_re      = 1'b0;
		mem_raddr   = '0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ins_d            = request.op == OP_INSERT;
					pos_d            = AW'(request.position);
					val_d            = in_val;
					rsp_d.status     = STATUS_OK;
					rsp_d.read_value = '0;
					case (request.op)
						OP_APPEND: begin
							done_d = 1'b1;
							if (full) begin
								rsp_d.status = STATUS_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(count_q);
								mem_wdata = in_val;
								count_d   = count_q + 1'b1;
							end
						end
						OP_INSERT: begin
							if (full) begin
								rsp_d.status = STATUS_FULL;
								done_d       = 1'b1;
							end else if (pos_ext > count_ext) begin
								rsp_d.status = STATUS_RANGE;
								done_d       = 1'b1;
							end else begin
								rd_ptr_d = AW'(count_q - 1'b1);
								moves_d  = CW'(count_ext - pos_ext);
								state_d  = ST_SHIFT;
							end
						end
						OP_DELETE: begin
							if (pos_ext >= count_ext) begin
								rsp_d.status = STATUS_RANGE;
								done_d       = 1'b1;
							end else begin
								rd_ptr_d = AW'(pos_ext + 1'b1);
								moves_d  = CW'(count_ext - pos_ext - 1'b1);
								state_d  = ST_SHIFT;
							end
						end
						default: begin
							if (pos_ext >= count_ext) begin
								rsp_d.status = STATUS_RANGE;
								done_d       = 1'b1;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(request.position);
								state_d   = ST_READ;
							end
						end
					endcase
				end
			end
			ST_READ: begin
				rsp_d.read_value = rd_ext[VALUE_W-1:0];
				done_d           = 1'b1;
				state_d          = ST_IDLE;
			end
			ST_SHIFT: begin
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = pend_addr_q;
					mem_wdata = mem_rdata;
				end
				if (moves_q != '0) begin
					mem_re      = 1'b1;
					mem_raddr   = rd_ptr_q;
					rd_ptr_d    = ins_q ? rd_ptr_q - 1'b1 : rd_ptr_q + 1'b1;
					moves_d     = moves_q - 1'b1;
					pend_d      = 1'b1;
					pend_addr_d = ins_q ? rd_ptr_q + 1'b1 : rd_ptr_q - 1'b1;
				end else if (!pend_q) begin
					if (ins_q) begin
						mem_we    = 1'b1;
						mem_waddr = pos_q;
						mem_wdata = val_q;
						count_d   = count_q + 1'b1;
					end else begin
						count_d = count_q - 1'b1;
					end
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (done_d) begin
			rsp_d.entry_count = COUNT_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
			moves_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
			moves_q <= moves_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_ptr_q    <= rd_ptr_d;
		pend_addr_q <= pend_addr_d;
		ins_q       <= ins_d;
		pos_q       <= pos_d;
		val_q       <= val_d;
		rsp_q       <= rsp_d;
	end

	`IIDL_ASSERT_IMP(a_no_rw_clash, clk, arst_n, mem_we && mem_re, mem_waddr != mem_raddr,
		"Entry move writes the entry it reads in the same cycle.")
	`IIDL_ASSERT_ALW(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH),
		"Entry count exceeds the list depth.")
	`IIDL_ASSERT_NXT(a_accept_progress, clk, arst_n, start && state_q == ST_IDLE,
		done_q || state_q != ST_IDLE, "Accepted transaction neither answered nor in progress.")
	`IIDL_ASSERT_IMP(a_pend_in_shift, clk, arst_n, pend_q, state_q == ST_SHIFT,
		"Pending entry move outside of a shift.")

endmodule

@@ src/indexed_insert_delete_list_unit.sv @@
// ============================================================================
// indexed_insert_delete_list_unit
// Bounded ordered list of signed values with append, insert, delete and read.
// ============================================================================
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      request (op, position, new_value)
// result    out        done strobe, one cycle    result (status, read_value, entry_count)
// config    in         cfg_valid and cfg_ready   cfg_data (list_limit)
//
// Append and every rejected request answer in the cycle after acceptance, and the
// next transaction can be accepted in that cycle. A read answers once its data
// has passed the registered memory read port and then the result register.
// An insert or delete stays busy while it moves entries, since the single
// memory write port moves one entry a cycle.
// Reset empties the list and sets the limit to sixteen; the entry memory is not
// cleared. The result is not held: done marks it for exactly one cycle.

module indexed_insert_delete_list_unit #(
	parameter int unsigned DEPTH      = iidl_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = iidl_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  iidl_pkg::req_t               request,
	output logic                         busy,
	output logic                         done,
	output iidl_pkg::rsp_t               result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [iidl_pkg::LIMIT_W-1:0] cfg_data
);

	import iidl_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [LIMIT_W-1:0]    limit_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [DATA_WIDTH-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	iidl_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.request    (request),
		.list_limit (limit_q),
		.busy       (busy),
		.done       (done),
		.result     (result),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	iidl_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the indexed insert/delete list unit. A queue of
// requests, limit writes and drain points feeds a falling-edge driver. A
// rising-edge monitor keeps a shadow copy of the list and checks every
// result strobe against the oldest predicted response.
// ============================================================================
module tb;
	import iidl_pkg::*;

	localparam int unsigned LIST_DEPTH  = DEPTH_DEF;
	localparam int unsigned STALL_LIMIT = 2000;

	typedef enum logic [1:0] {
		ITEM_REQ,
		ITEM_LIMIT,
		ITEM_DRAIN
	} item_kind_t;

	typedef struct packed {
		item_kind_t         kind;
		req_t               req;
		logic [LIMIT_W-1:0] limit;
	} pending_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	req_t               request   = '0;
	logic               cfg_valid = 1'b0;
	logic [LIMIT_W-1:0] cfg_data  = '0;
	logic               busy;
	logic               done;
	rsp_t               result;
	logic               cfg_ready;

	pending_t pending_ops[$];
	rsp_t     expected_rsp[$];

	logic signed [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
	int                        shadow_count = 0;
	logic [LIMIT_W-1:0]        shadow_limit = LIMIT_RESET;

	bit req_fire = 1'b0;
	bit cfg_fire = 1'b0;

	int sent_items    = 0;
	int results_seen  = 0;
	int limit_writes  = 0;
	int mismatches    = 0;
	int stall_cycles  = 0;
	int status_hits [3] = '{0, 0, 0};

	indexed_insert_delete_list_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic rsp_t list_apply(req_t rq);
		rsp_t r;
		int   cap;
		bit   full;
		int   i;
		r = '0;
		r.status = STATUS_OK;
		cap = (shadow_limit > LIST_DEPTH) ? LIST_DEPTH : shadow_limit;
		full = shadow_count >= cap;
		case (rq.op)
			OP_APPEND: begin
				if (full) begin
					r.status = STATUS_FULL;
				end else begin
					shadow_entries[shadow_count] = rq.new_value;
					shadow_count++;
				end
			end
			OP_INSERT: begin
				if (full) begin
					r.status = STATUS_FULL;
				end else if (rq.position > shadow_count) begin
					r.status = STATUS_RANGE;
				end else begin
					for (i = shadow_count; i > rq.position; i--)
						shadow_entries[i] = shadow_entries[i - 1];
					shadow_entries[rq.position] = rq.new_value;
					shadow_count++;
				end
			end
			OP_DELETE: begin
				if (rq.position >= shadow_count) begin
					r.status = STATUS_RANGE;
				end else begin
					for (i = rq.position; i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i + 1];
					shadow_count--;
				end
			end
			default: begin
				if (rq.position >= shadow_count)
					r.status = STATUS_RANGE;
				else
					r.read_value = shadow_entries[rq.position];
			end
		endcase
		r.entry_count = shadow_count[COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	task automatic queue_req(logic [OP_W-1:0] op, int pos, logic [VALUE_W-1:0] val);
		pending_t p;
		p = '0;
		p.kind = ITEM_REQ;
		p.req.op = op;
		p.req.position = pos[POS_W-1:0];
		p.req.new_value = val;
		pending_ops.push_back(p);
	endtask

	task automatic queue_limit(int lim);
		pending_t p;
		p = '0;
		p.kind = ITEM_LIMIT;
		p.limit = lim[LIMIT_W-1:0];
		pending_ops.push_back(p);
	endtask

	task automatic queue_drain();
		pending_t p;
		p = '0;
		p.kind = ITEM_DRAIN;
		pending_ops.push_back(p);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	always @(negedge clk) begin : drive_proc
		logic     nxt_start;
		logic     nxt_cfg;
		bit       quiet;
		pending_t item;
		if (arst_n) begin
			nxt_start = start && !req_fire;
			nxt_cfg = cfg_valid && !cfg_fire;
			quiet = sent_items >= 400 && sent_items < 540;
			if (!nxt_start && !nxt_cfg && pending_ops.size() != 0 &&
					(quiet || $urandom_range(99) >= 15)) begin
				item = pending_ops[0];
				case (item.kind)
					ITEM_REQ: begin
						request <= item.req;
						nxt_start = 1'b1;
						void'(pending_ops.pop_front());
						sent_items++;
					end
					ITEM_LIMIT: begin
						if (expected_rsp.size() == 0 && !busy) begin
							cfg_data <= item.limit;
							nxt_cfg = 1'b1;
							void'(pending_ops.pop_front());
						end
					end
					default: begin
						if (expected_rsp.size() == 0 && !busy)
							void'(pending_ops.pop_front());
					end
				endcase
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	always @(posedge clk) begin : monitor_proc
		rsp_t want;
		req_fire = 1'b0;
		cfg_fire = 1'b0;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (result.status < 3)
					status_hits[result.status]++;
				if (expected_rsp.size() == 0) begin
					report_mismatch($sformatf("result with no request pending: %h", result));
				end else begin
					want = expected_rsp.pop_front();
					if (result.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							result.status, want.status));
					if (result.read_value !== want.read_value)
						report_mismatch($sformatf("read_value got %h want %h",
							result.read_value, want.read_value));
					if (result.entry_count !== want.entry_count)
						report_mismatch($sformatf("entry_count got %0d want %0d",
							result.entry_count, want.entry_count));
				end
			end
			if (start && !busy) begin
				expected_rsp.push_back(list_apply(request));
				req_fire = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				shadow_limit = cfg_data;
				limit_writes++;
				cfg_fire = 1'b1;
			end
			if (done || req_fire || cfg_fire)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	initial begin : watchdog
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin : main_proc
		int phase;
		int k;
		int r;
		int lim;
		int pos;
		logic [OP_W-1:0] op;

		// Directed part: empty list, both ends of the value range, insert at
		// the front and at the end, bad positions, a full list meeting a bad
		// position, a limit below the count, and a zero and saturating limit.
		queue_req(OP_READ, 0, '0);
		queue_req(OP_DELETE, 0, '0);
		queue_req(OP_INSERT, 1, 32'h1234_5678);
		queue_req(OP_APPEND, 0, 32'h7fff_ffff);
		queue_req(OP_APPEND, 16, 32'h8000_0000);
		queue_req(OP_INSERT, 0, 32'hffff_ffff);
		queue_req(OP_INSERT, 3, 32'h0000_0000);
		queue_req(OP_INSERT, 5, 32'h5555_5555);
		for (k = 0; k < 5; k++)
			queue_req(OP_READ, k, $urandom);
		queue_req(OP_DELETE, 1, '0);
		queue_req(OP_DELETE, 3, '0);
		queue_limit(3);
		queue_req(OP_APPEND, 0, 32'h0bad_cafe);
		queue_req(OP_INSERT, 16, 32'h0bad_cafe);
		queue_req(OP_READ, 2, '0);
		queue_limit(1);
		queue_req(OP_INSERT, 0, 32'h0bad_cafe);
		queue_req(OP_DELETE, 0, '0);
		queue_req(OP_READ, 1, '0);
		queue_limit(0);
		queue_req(OP_APPEND, 0, 32'h0bad_cafe);
		queue_req(OP_INSERT, 0, 32'h0bad_cafe);
		queue_limit(31);
		queue_req(OP_APPEND, 0, 32'h0f0f_0f0f);
		queue_req(OP_INSERT, 0, 32'ha5a5_a5a5);
		queue_limit(16);

		// Random part in phases that fill, mix and empty the list.
		for (phase = 0; phase < 12; phase++) begin
			r = $urandom_range(99);
			if (r < 12)
				lim = 16;
			else if (r < 20)
				lim = 1;
			else if (r < 24)
				lim = 0;
			else if (r < 30)
				lim = 31;
			else
				lim = $urandom_range(1, 16);
			queue_limit(lim);
			for (k = 0; k < 78; k++) begin
				r = $urandom_range(99);
				case (phase % 3)
					0: op = (r < 45) ? OP_APPEND : (r < 70) ? OP_INSERT :
						(r < 80) ? OP_DELETE : OP_READ;
					1: op = (r < 25) ? OP_APPEND : (r < 50) ? OP_INSERT :
						(r < 75) ? OP_DELETE : OP_READ;
					default: op = (r < 10) ? OP_APPEND : (r < 20) ? OP_INSERT :
						(r < 70) ? OP_DELETE : OP_READ;
				endcase
				pos = ($urandom_range(1) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 4);
				queue_req(op, pos, pick_value());
				if (k == 39 && phase % 4 == 1)
					queue_drain();
			end
		end
		queue_limit(16);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || start || cfg_valid || expected_rsp.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);

		if (expected_rsp.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_rsp.size()));
		$display("Covered %0d requests, %0d results, %0d limit writes.",
			sent_items, results_seen, limit_writes);
		$display("Results by status: ok %0d, out of range %0d, full %0d; mismatches %0d.",
			status_hits[0], status_hits[1], status_hits[2], mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/iidl_pkg.sv
src/iidl_mem.sv
src/iidl_ctrl.sv
src/indexed_insert_delete_list_unit.sv
tb/sv/tb.sv
